@@ rtl/lcs_pkg.sv @@
package lcs_pkg;

	// longest string held, in bytes
	localparam int MAX_LEN = 64;
	localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	// field widths fixed by the port list
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 7;
	localparam int START_W = 6;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic load;   // first-string byte written to cell load_idx
		logic step;   // second-string byte compared in all cells
		logic scan;   // best records shift towards cell 0, runs cleared
	} cell_cmd_t;

	// best run ending in a cell: length and start in the first string
	typedef struct packed {
		len_t len;
		idx_t start;
	} best_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RD,
		ST_LD,
		ST_WT
	} state_t;

endpackage

@@ rtl/lcs_ram.sv @@
module lcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/lcs_cell.sv @@
// One column of the run-length recurrence: holds one byte of the first string.
module lcs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  lcs_pkg::cell_cmd_t  cmd,
	input  lcs_pkg::idx_t       idx,
	input  lcs_pkg::idx_t       load_idx,
	input  lcs_pkg::byte_t      load_byte,
	input  lcs_pkg::byte_t      b_byte,
	input  lcs_pkg::len_t       run_in,
	output lcs_pkg::len_t       run_out,
	input  lcs_pkg::best_t      best_in,
	output lcs_pkg::best_t      best_out
);

	lcs_pkg::byte_t a_q;
	logic           valid_q;
	lcs_pkg::len_t  run_q;
	lcs_pkg::best_t best_q;
	lcs_pkg::len_t  run_n;
	lcs_pkg::idx_t  start_n;

	// run ending here = left neighbour's previous run + 1 on a match
	assign run_n   = (valid_q && (a_q == b_byte)) ?
		run_in + lcs_pkg::LEN_W'(1) : '0;
	assign start_n = lcs_pkg::IDX_W'(lcs_pkg::LEN_W'(idx) + lcs_pkg::LEN_W'(1) - run_n);

	assign run_out  = run_q;
	assign best_out = best_q;

	always_ff @(posedge clk) begin
		if (cmd.load && (load_idx == idx)) begin
			a_q <= load_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			run_q   <= '0;
			best_q  <= '0;
		end else if (cmd.scan) begin
			valid_q <= 1'b0;
			run_q   <= '0;
			best_q  <= best_in;
		end else begin
			if (cmd.load && (load_idx == idx)) begin
				valid_q <= 1'b1;
			end
			if (cmd.step) begin
				run_q <= run_n;
				// strict: within one cell an equal run has the same start
				if (run_n > best_q.len) begin
					best_q <= '{len: run_n, start: start_n};
				end
			end
		end
	end

endmodule

@@ rtl/longest_common_substring_core.sv @@
// Longest common substring of two byte strings. Items of the first string
// (req_type 0) are taken one per cycle and written both into a byte RAM and
// into a chain of MAX_LEN (64) cells; the item with last_of_string ends it.
// Items of the second string (req_type 1) are also taken one per cycle, and
// each byte is compared against every cell as it arrives, each cell growing
// the run handed on by its left neighbour, so the search costs nothing extra
// while loading. An item of the wrong string is taken and ignored. After the
// last item of the second string the block stops taking items and shifts the
// cells' best runs out through the chain into a compare stage, over the
// whole chain length; this scan also runs when an argument was NULL, as it
// clears the cells for the next pair. Then the match is read from the RAM,
// one result item per byte, each passing through a RAM read, the output
// register and the handshake, plus any wait on out_ready. A NULL argument
// or an empty match gives one result item of length 0. Bytes beyond
// MAX_LEN are dropped and the overflow flag is set on every result item of
// that pair. Ties go to the earliest start in the first string.
module longest_common_substring_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] char_byte,
	input  logic       has_byte,
	input  logic       last_of_string,
	input  logic       arg_is_null,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result_byte,
	output logic [6:0] match_length,
	output logic [5:0] match_start,
	output logic       null_result,
	output logic       overflow,
	output logic       last_result
);

	lcs_pkg::state_t state_q, state_n;

	// pair loading state
	logic           phase_q;
	lcs_pkg::len_t  cnt1_q, cnt2_q;
	logic           null_q, ovf_q;

	// answer state
	logic           ans_null_q, ans_ovf_q;
	lcs_pkg::best_t red_q, red_n;
	lcs_pkg::idx_t  scan_q, n_q;

	// output register
	lcs_pkg::byte_t out_byte_q;
	lcs_pkg::len_t  out_len_q;
	lcs_pkg::idx_t  out_start_q;
	logic           out_null_q, out_last_q;

	logic in_fire, ph_ok, has_ok, room1, room2;
	logic load_go, step_go, ovf_now, fin, better, scan_done, out_fire;

	lcs_pkg::cell_cmd_t cmd;
	lcs_pkg::byte_t     rd_data;
	lcs_pkg::idx_t      rd_addr;
	lcs_pkg::len_t      run_w  [lcs_pkg::MAX_LEN];
	lcs_pkg::best_t     best_w [lcs_pkg::MAX_LEN];

	// ---- input decode ----
	assign in_fire = in_valid && in_ready;
	assign ph_ok   = in_fire && (req_type == phase_q);
	assign has_ok  = ph_ok && !arg_is_null && has_byte;
	assign room1   = cnt1_q < lcs_pkg::LEN_W'(lcs_pkg::MAX_LEN);
	assign room2   = cnt2_q < lcs_pkg::LEN_W'(lcs_pkg::MAX_LEN);
	assign load_go = has_ok && !phase_q && room1;
	assign step_go = has_ok && phase_q && room2;
	assign ovf_now = has_ok && (phase_q ? !room2 : !room1);
	// last item of the second string closes the pair
	assign fin     = ph_ok && last_of_string && phase_q;

	assign cmd = '{load: load_go, step: step_go, scan: (state_q == lcs_pkg::ST_SCAN)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			cnt1_q  <= '0;
			cnt2_q  <= '0;
			null_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (fin) begin
			phase_q <= 1'b0;
			cnt1_q  <= '0;
			cnt2_q  <= '0;
			null_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (ph_ok) begin
			if (arg_is_null) begin
				null_q <= 1'b1;
			end
			if (ovf_now) begin
				ovf_q <= 1'b1;
			end
			if (load_go) begin
				cnt1_q <= cnt1_q + lcs_pkg::LEN_W'(1);
			end
			if (step_go) begin
				cnt2_q <= cnt2_q + lcs_pkg::LEN_W'(1);
			end
			if (last_of_string) begin
				phase_q <= 1'b1;
			end
		end
	end

	// ---- first string store, read back for the answer ----
	assign rd_addr = red_q.start + n_q;

	lcs_ram #(
		.WIDTH (lcs_pkg::BYTE_W),
		.DEPTH (lcs_pkg::MAX_LEN)
	) u_first_ram (
		.clk     (clk),
		.wr_en   (load_go),
		.wr_addr (cnt1_q[lcs_pkg::IDX_W-1:0]),
		.wr_data (char_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// ---- chain of cells: runs move right, best records move left on scan ----
	for (genvar g = 0; g < lcs_pkg::MAX_LEN; g++) begin : g_cell
		lcs_pkg::len_t  run_l;
		lcs_pkg::best_t best_r;

		if (g == 0) begin : g_first
			assign run_l = '0;
		end else begin : g_mid
			assign run_l = run_w[g-1];
		end

		if (g == lcs_pkg::MAX_LEN - 1) begin : g_end
			assign best_r = '0;
		end else begin : g_rest
			assign best_r = best_w[g+1];
		end

		lcs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.idx       (lcs_pkg::IDX_W'(g)),
			.load_idx  (cnt1_q[lcs_pkg::IDX_W-1:0]),
			.load_byte (char_byte),
			.b_byte    (char_byte),
			.run_in    (run_l),
			.run_out   (run_w[g]),
			.best_in   (best_r),
			.best_out  (best_w[g])
		);
	end

	// ---- reduction at the head of the chain: longest, then earliest start ----
	assign better = (best_w[0].len > red_q.len) ||
		((best_w[0].len == red_q.len) && (best_w[0].len != '0) &&
		 (best_w[0].start < red_q.start));
	assign red_n     = better ? best_w[0] : red_q;
	assign scan_done = (scan_q == lcs_pkg::IDX_W'(lcs_pkg::MAX_LEN - 1));
	assign out_fire  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q      <= '0;
			scan_q     <= '0;
			n_q        <= '0;
			ans_null_q <= 1'b0;
			ans_ovf_q  <= 1'b0;
		end else if (fin) begin
			red_q      <= '0;
			scan_q     <= '0;
			ans_null_q <= null_q || arg_is_null;
			ans_ovf_q  <= ovf_q || ovf_now;
		end else if (state_q == lcs_pkg::ST_SCAN) begin
			red_q  <= red_n;
			scan_q <= scan_q + lcs_pkg::IDX_W'(1);
			n_q    <= '0;
		end else if ((state_q == lcs_pkg::ST_WT) && out_fire) begin
			n_q <= n_q + lcs_pkg::IDX_W'(1);
		end
	end

	// ---- output register ----
	always_ff @(posedge clk) begin
		if ((state_q == lcs_pkg::ST_SCAN) && scan_done) begin
			// null or empty answer: a single zero item
			out_byte_q  <= '0;
			out_len_q   <= '0;
			out_start_q <= '0;
			out_null_q  <= ans_null_q;
			out_last_q  <= 1'b1;
		end else if (state_q == lcs_pkg::ST_LD) begin
			out_byte_q  <= rd_data;
			out_len_q   <= red_q.len;
			out_start_q <= red_q.start;
			out_null_q  <= 1'b0;
			out_last_q  <= (lcs_pkg::LEN_W'(n_q) + lcs_pkg::LEN_W'(1)) == red_q.len;
		end
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			lcs_pkg::ST_IDLE: begin
				if (fin) begin
					state_n = lcs_pkg::ST_SCAN;
				end
			end
			lcs_pkg::ST_SCAN: begin
				if (scan_done) begin
					if (ans_null_q || (red_n.len == '0)) begin
						state_n = lcs_pkg::ST_WT;
					end else begin
						state_n = lcs_pkg::ST_RD;
					end
				end
			end
			lcs_pkg::ST_RD: begin
				state_n = lcs_pkg::ST_LD;
			end
			lcs_pkg::ST_LD: begin
				state_n = lcs_pkg::ST_WT;
			end
			lcs_pkg::ST_WT: begin
				if (out_ready) begin
					state_n = out_last_q ? lcs_pkg::ST_IDLE : lcs_pkg::ST_RD;
				end
			end
			default: begin
				state_n = lcs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			lcs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			lcs_pkg::ST_WT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready  = 1'b0;
				out_valid = 1'b0;
			end
		endcase
	end

	assign result_byte  = out_byte_q;
	assign match_length = out_len_q;
	assign match_start  = lcs_pkg::START_W'(out_start_q);
	assign null_result  = out_null_q;
	assign overflow     = ans_ovf_q;
	assign last_result  = out_last_q;

endmodule

@@ rtl/lcs_checker.sv @@
module lcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] result_byte,
	input logic [6:0] match_length,
	input logic [5:0] match_start,
	input logic       null_result,
	input logic       last_result
);

	// a stalled result item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_byte) &&
		$stable(match_length) && $stable(last_result))
	else $error("result item changed while stalled");

	// no item taken while an answer is being delivered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
	else $error("input taken during answer");

	// null answer is one zero-length item
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && null_result |-> last_result && (match_length == 7'd0) &&
		(match_start == 6'd0))
	else $error("malformed null answer");

	// a non-final item belongs to a real match within the first string
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> (match_length != 7'd0) &&
		((7'(match_start) + match_length) <= 7'd64))
	else $error("non-final item outside a match");

endmodule

bind longest_common_substring_core lcs_checker u_lcs_checker (.*);
